### hw/rtl/mpic_pkg.sv
package mpic_pkg;

  // Field widths
  parameter int unsigned AddrW    = 64;
  parameter int unsigned SysW     = 16;
  parameter int unsigned CountW   = 64;
  parameter int unsigned HitW     = 32;
  parameter int unsigned LimitW   = 31;
  parameter int unsigned CfgDataW = 64;
  parameter int unsigned CfgIdxW  = 3;

  // Default depth of the queues between the stages
  parameter int unsigned QueueDepthDefault = 2;

  // Syscall numbers that gate tracking
  parameter logic [SysW-1:0] SyscallStart = 16'd888;
  parameter logic [SysW-1:0] SyscallStop  = 16'd889;

  // Phase code after the last marker has fired
  parameter logic [1:0] PhaseDone = 2'd3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MARKER0 = 3'd0,
    CFG_MARKER1 = 3'd1,
    CFG_MARKER2 = 3'd2,
    CFG_LIMIT0  = 3'd3,
    CFG_LIMIT1  = 3'd4,
    CFG_LIMIT2  = 3'd5
  } cfg_idx_e;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_INSTR = 3'd3,
    OP_HIT0  = 3'd4,
    OP_HIT1  = 3'd5,
    OP_HIT2  = 3'd6
  } op_e;

  typedef struct packed {
    logic              command;
    logic [AddrW-1:0]  instruction_address;
    logic [SysW-1:0]   syscall_number;
  } item_t;

  typedef struct packed {
    logic [1:0]        marker_fired;
    logic [CountW-1:0] instructions_counted;
    logic [1:0]        phase_now;
    logic              tracking_on;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

### hw/rtl/mpic_fifo.sv
module mpic_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/mpic_front.sv
module mpic_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpic_pkg::cfg_wr_t cfg_i,
  input  logic              push_i,
  input  mpic_pkg::item_t   item_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output mpic_pkg::op_e     q_op_o
);

  import mpic_pkg::*;

  logic [AddrW-1:0] marker_q [3];

  // Hold the marker addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q[0] <= '0;
      marker_q[1] <= '0;
      marker_q[2] <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_MARKER0: marker_q[0] <= cfg_i.data;
        CFG_MARKER1: marker_q[1] <= cfg_i.data;
        CFG_MARKER2: marker_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Classify the word; marker 0 wins over 1, 1 over 2
  always_comb begin
    q_op_o = OP_NONE;
    if (item_i.command) begin
      if (item_i.syscall_number == SyscallStart) begin
        q_op_o = OP_START;
      end else if (item_i.syscall_number == SyscallStop) begin
        q_op_o = OP_STOP;
      end
    end else if (item_i.instruction_address != '0) begin
      if (item_i.instruction_address == marker_q[0]) begin
        q_op_o = OP_HIT0;
      end else if (item_i.instruction_address == marker_q[1]) begin
        q_op_o = OP_HIT1;
      end else if (item_i.instruction_address == marker_q[2]) begin
        q_op_o = OP_HIT2;
      end else begin
        q_op_o = OP_INSTR;
      end
    end
  end

  assign q_wr_o = push_i && !q_full_i;

endmodule

### hw/rtl/mpic_back.sv
module mpic_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpic_pkg::cfg_wr_t cfg_i,
  input  logic              q_empty_i,
  input  mpic_pkg::op_e     q_op_i,
  output logic              q_rd_o,
  input  logic              res_full_i,
  output logic              res_wr_o,
  output mpic_pkg::result_t res_o
);

  import mpic_pkg::*;

  logic [LimitW-1:0] limit_q [3];
  logic [HitW-1:0]   hit_q [3];
  logic [HitW-1:0]   hit_d [3];
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [1:0]        phase_q, phase_d;
  logic              trk_q, trk_d;
  logic [1:0]        m;
  logic              is_hit;
  logic              is_instr;
  logic [HitW-1:0]   hit_new;
  logic [1:0]        fired;
  logic [CountW-1:0] report;

  assign q_rd_o   = !q_empty_i && !res_full_i;
  assign res_wr_o = q_rd_o;

  // Decode the marker index of a hit
  always_comb begin
    m        = 2'd0;
    is_hit   = 1'b0;
    is_instr = 1'b0;
    case (q_op_i)
      OP_INSTR: is_instr = 1'b1;
      OP_HIT0: begin
        is_instr = 1'b1;
        is_hit   = 1'b1;
        m        = 2'd0;
      end
      OP_HIT1: begin
        is_instr = 1'b1;
        is_hit   = 1'b1;
        m        = 2'd1;
      end
      OP_HIT2: begin
        is_instr = 1'b1;
        is_hit   = 1'b1;
        m        = 2'd2;
      end
      default: ;
    endcase
  end

  // Execute one word against the tracking state
  always_comb begin
    trk_d   = trk_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    fired   = 2'd0;
    report  = '0;
    hit_new = hit_q[m] + HitW'(1);
    if (q_rd_o) begin
      if (q_op_i == OP_START) begin
        trk_d = 1'b1;
      end else if (q_op_i == OP_STOP) begin
        trk_d = 1'b0;
      end
      if (is_instr && trk_q && (phase_q != PhaseDone)) begin
        cnt_d = cnt_q + CountW'(1);
      end
      if (is_hit && trk_q && (phase_q == m)) begin
        hit_d[m] = hit_new;
        if (hit_new >= {1'b0, limit_q[m]}) begin
          report  = cnt_d;
          fired   = m + 2'd1;
          phase_d = m + 2'd1;
          if (m != 2'd2) begin
            cnt_d = '0;
          end
        end
      end
    end
  end

  assign res_o.marker_fired         = fired;
  assign res_o.instructions_counted = report;
  assign res_o.phase_now            = phase_d;
  assign res_o.tracking_on          = trk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= 1'b0;
      phase_q <= 2'd0;
      cnt_q   <= '0;
      hit_q   <= '{default: '0};
    end else begin
      trk_q   <= trk_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hit_q   <= hit_d;
    end
  end

  // Hold the hit limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '{default: '0};
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_LIMIT0: limit_q[0] <= cfg_i.data[LimitW-1:0];
        CFG_LIMIT1: limit_q[1] <= cfg_i.data[LimitW-1:0];
        CFG_LIMIT2: limit_q[2] <= cfg_i.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/marker_phase_instruction_counter.sv
// Trace-trigger sequencer for retired-instruction and syscall words. It takes one
// word per cycle while its classify queue has room and returns one result word
// per input word, in order; a result becomes visible once its word has passed the
// classify queue and then the result queue. The front compares the address with
// the three markers, the back updates the 64-bit instruction counter, hit counts
// and phase with one registered update per word, so the sustained rate is one
// word per cycle as long as results are popped. Configure only while idle.
module marker_phase_instruction_counter #(
  parameter int unsigned QueueDepth = mpic_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpic_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mpic_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  mpic_pkg::item_t                item_i,
  output logic                           empty,
  input  logic                           pop,
  output mpic_pkg::result_t              result_o
);

  import mpic_pkg::*;

  localparam int unsigned OpW  = $bits(op_e);
  localparam int unsigned ResW = $bits(result_t);

  cfg_wr_t         cfg;
  logic            iq_wr, iq_full, iq_empty, iq_rd;
  op_e             front_op;
  logic [OpW-1:0]  iq_data;
  logic            oq_wr, oq_full;
  result_t         back_res;
  logic [ResW-1:0] oq_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_data_i;

  // Accept and classify
  mpic_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .push_i  (push),
    .item_i  (item_i),
    .q_full_i(iq_full),
    .q_wr_o  (iq_wr),
    .q_op_o  (front_op)
  );

  assign full = iq_full;

  // Decouple front from back
  mpic_fifo #(
    .Depth(QueueDepth),
    .Width(OpW)
  ) u_op_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(iq_wr),
    .wr_data_i (front_op),
    .full_o    (iq_full),
    .rd_ready_i(iq_rd),
    .rd_data_o (iq_data),
    .empty_o   (iq_empty)
  );

  // Execute against the phase state
  mpic_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (iq_empty),
    .q_op_i    (op_e'(iq_data)),
    .q_rd_o    (iq_rd),
    .res_full_i(oq_full),
    .res_wr_o  (oq_wr),
    .res_o     (back_res)
  );

  // Hold results until popped
  mpic_fifo #(
    .Depth(QueueDepth),
    .Width(ResW)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(oq_wr),
    .wr_data_i (back_res),
    .full_o    (oq_full),
    .rd_ready_i(pop),
    .rd_data_o (oq_data),
    .empty_o   (empty)
  );

  assign result_o = result_t'(oq_data);

  // Back never writes a full result queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_wr |-> !oq_full)
    else $error("result queue written while full");

  // A word pushed into an idle block shows a result once it has passed the op queue and the result queue
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && iq_empty && empty) |=> ##1 !empty)
    else $error("result missing after push into idle block");

  // A fired marker leaves the phase right after it
  a_fire_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.marker_fired != 2'd0)) |->
      (result_o.phase_now == result_o.marker_fired))
    else $error("fired marker and phase disagree");

  // No count is reported without a firing
  a_quiet_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.marker_fired == 2'd0)) |->
      (result_o.instructions_counted == '0))
    else $error("count reported without a firing");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mpic_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Command codes of an input word
  localparam logic CMD_INSTR   = 1'b0;
  localparam logic CMD_SYSCALL = 1'b1;

  // Register indexes that the block does not decode
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 3'd7;

  // Fixed addresses for the directed part
  localparam logic [AddrW-1:0] AddrA = 64'h0000_0000_0040_1000;
  localparam logic [AddrW-1:0] AddrB = 64'h0000_0000_0040_2000;
  localparam logic [AddrW-1:0] AddrC = '1;

  typedef struct {
    item_t   w;
    bit      has_want;
    result_t want;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                push        = 1'b0;
  logic                full;
  item_t               item_i      = '0;
  logic                empty;
  logic                pop         = 1'b0;
  result_t             result_o;

  // Predictor copy of registers and state
  logic [AddrW-1:0]    marker_addr [3];
  logic [LimitW-1:0]   hit_limit [3];
  logic [HitW-1:0]     hit_cnt [3];
  logic [CountW-1:0]   instr_cnt;
  logic [1:0]          cur_phase;
  logic                trk_on;

  result_t             pending_results [$];
  stim_row_t           directed_rows [$];
  int                  sent_words;
  int                  popped_words;
  int                  mismatch_count;

  marker_phase_instruction_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Advance the predicted state by one word and return the expected result word
  function automatic result_t track_word(item_t w);
    result_t r;
    int      m;
    r = '0;
    m = 3;
    if (w.command == CMD_SYSCALL) begin
      if (w.syscall_number == SyscallStart) begin
        trk_on = 1'b1;
      end else if (w.syscall_number == SyscallStop) begin
        trk_on = 1'b0;
      end
    end else if (w.instruction_address != '0) begin
      if (trk_on && cur_phase != PhaseDone) begin
        instr_cnt = instr_cnt + 1'b1;
      end
      // Earlier markers shadow later ones
      if (w.instruction_address == marker_addr[0]) begin
        m = 0;
      end else if (w.instruction_address == marker_addr[1]) begin
        m = 1;
      end else if (w.instruction_address == marker_addr[2]) begin
        m = 2;
      end
      if (m < 3 && trk_on && cur_phase == 2'(m)) begin
        hit_cnt[m] = hit_cnt[m] + 1'b1;
        if (hit_cnt[m] >= {1'b0, hit_limit[m]}) begin
          r.marker_fired         = 2'(m + 1);
          r.instructions_counted = instr_cnt;
          if (m < 2) begin
            instr_cnt = '0;
          end
          cur_phase = 2'(m + 1);
        end
      end
    end
    r.phase_now   = cur_phase;
    r.tracking_on = trk_on;
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic cmd, logic [AddrW-1:0] addr, logic [SysW-1:0] sys,
                                       bit has_want, logic [1:0] fired,
                                       logic [CountW-1:0] cnt, logic [1:0] ph, logic trk);
    stim_row_t s;
    s.w.command                 = cmd;
    s.w.instruction_address     = addr;
    s.w.syscall_number          = sys;
    s.has_want                  = has_want;
    s.want.marker_fired         = fired;
    s.want.instructions_counted = cnt;
    s.want.phase_now            = ph;
    s.want.tracking_on          = trk;
    return s;
  endfunction

  // Mostly instructions, 36 percent of them on marker addresses, plus syscalls and noise
  function automatic item_t rand_word();
    item_t w;
    int    k;
    w.instruction_address = rand64();
    w.syscall_number      = SysW'($urandom);
    if ($urandom_range(99) < 15) begin
      w.command = CMD_SYSCALL;
      k = $urandom_range(9);
      if (k < 5) begin
        w.syscall_number = SyscallStart;
      end else if (k < 7) begin
        w.syscall_number = SyscallStop;
      end
    end else begin
      w.command = CMD_INSTR;
      k = $urandom_range(99);
      if (k < 36) begin
        w.instruction_address = marker_addr[$urandom_range(2)];
      end else if (k < 41) begin
        w.instruction_address = '0;
      end else if (k < 46) begin
        w.instruction_address = '1;
      end else if (k < 50) begin
        w.instruction_address = AddrW'($urandom_range(255));
      end
    end
    return w;
  endfunction

  // Write one register; call at a falling edge, returns at a falling edge with we still high
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MARKER0: marker_addr[0] = data;
      CFG_MARKER1: marker_addr[1] = data;
      CFG_MARKER2: marker_addr[2] = data;
      CFG_LIMIT0:  hit_limit[0]   = data[LimitW-1:0];
      CFG_LIMIT1:  hit_limit[1]   = data[LimitW-1:0];
      CFG_LIMIT2:  hit_limit[2]   = data[LimitW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one word until accepted; enter and leave at a falling edge
  task automatic send_word(item_t w);
    bit taken;
    while (!(sent_words >= 900 && sent_words < 1100) && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= w;
    taken  = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !full;
      @(negedge clk_i);
    end
    sent_words++;
  endtask

  // Stop offering and wait for every expected word, plus the pipeline latency
  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_words(int n);
    item_t w;
    cfg_we_i <= 1'b0;
    repeat (n) begin
      w = rand_word();
      send_word(w);
      pending_results.push_back(track_word(w));
    end
    drain();
  endtask

  // Result side: random pops, one long hold-off, compare against the oldest expectation
  initial begin
    int      hold_left;
    bit      held;
    result_t want;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && popped_words >= 500) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (popped_words >= 900 && popped_words < 1100) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 29);
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        popped_words++;
        if (pending_results.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_o.marker_fired !== want.marker_fired) begin
            $error("marker_fired: expected %0d, actual %0d",
                   want.marker_fired, result_o.marker_fired);
            mismatch_count++;
          end
          if (result_o.instructions_counted !== want.instructions_counted) begin
            $error("instructions_counted: expected %0d, actual %0d",
                   want.instructions_counted, result_o.instructions_counted);
            mismatch_count++;
          end
          if (result_o.phase_now !== want.phase_now) begin
            $error("phase_now: expected %0d, actual %0d",
                   want.phase_now, result_o.phase_now);
            mismatch_count++;
          end
          if (result_o.tracking_on !== want.tracking_on) begin
            $error("tracking_on: expected %0d, actual %0d",
                   want.tracking_on, result_o.tracking_on);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t r;
    result_t   pred;
    sent_words     = 0;
    popped_words   = 0;
    mismatch_count = 0;
    for (int i = 0; i < 3; i++) begin
      marker_addr[i] = '0;
      hit_limit[i]   = '0;
      hit_cnt[i]     = '0;
    end
    instr_cnt = '0;
    cur_phase = '0;
    trk_on    = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero limit on marker 0, two hits on marker 1, widest limit on marker 2
    cfg_write(CFG_MARKER0, AddrA);
    cfg_write(CFG_MARKER1, AddrB);
    cfg_write(CFG_MARKER2, AddrC);
    cfg_write(CFG_LIMIT0, '0);
    cfg_write(CFG_LIMIT1, 64'd2);
    cfg_write(CFG_LIMIT2, '1);
    cfg_we_i <= 1'b0;

    // Directed table
    directed_rows.push_back(mk_row(CMD_INSTR, AddrA, '0, 1, 2'd0, '0, 2'd0, 1'b0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, AddrA, 16'd887, 1, 2'd0, '0, 2'd0, 1'b0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, '0, 16'd890, 1, 2'd0, '0, 2'd0, 1'b0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, '1, SyscallStart, 1, 2'd0, '0, 2'd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, '0, SyscallStart, 1, 2'd0, '0, 2'd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, 64'd1, '1, 1, 2'd0, '0, 2'd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrC, '0, 1, 2'd0, '0, 2'd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrB, '0, 1, 2'd0, '0, 2'd0, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrA, '0, 1, 2'd1, 64'd4, 2'd1, 1'b1));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrA, '0, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrB, '0, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, AddrB, SyscallStop, 1, 2'd0, '0, 2'd1, 1'b0));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrB, '0, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, '0, '0, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, '0, SyscallStart, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_INSTR, AddrC, SyscallStop, 0, '0, '0, '0, '0));
    directed_rows.push_back(mk_row(CMD_SYSCALL, rand64(), '1, 0, '0, '0, '0, '0));

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_word(r.w);
      pred = track_word(r.w);
      pending_results.push_back(r.has_want ? r.want : pred);
    end
    drain();

    // Phase one held by the widest limit
    cfg_write(CFG_MARKER0, rand64());
    cfg_write(CFG_MARKER1, rand64());
    cfg_write(CFG_MARKER2, rand64());
    cfg_write(CFG_LIMIT0, rand64());
    cfg_write(CFG_LIMIT1, '1);
    run_words(250);

    // Marker 1 shadowed by marker 0
    cfg_write(CFG_MARKER1, marker_addr[0]);
    cfg_write(CFG_LIMIT1, 64'd1);
    run_words(200);

    // Marker 1 distinct again with a modest limit; undecoded indexes are ignored
    cfg_write(CFG_MARKER1, rand64());
    cfg_write(CFG_LIMIT1, 64'($urandom_range(30, 8)));
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, rand64());
    run_words(250);

    // Marker 2 shadowed by marker 1 with a zero limit
    cfg_write(CFG_MARKER2, marker_addr[1]);
    cfg_write(CFG_LIMIT2, '0);
    run_words(200);

    // Marker 2 distinct with a larger limit, marker 0 at the top address
    cfg_write(CFG_MARKER2, rand64());
    cfg_write(CFG_MARKER0, '1);
    cfg_write(CFG_LIMIT0, rand64());
    cfg_write(CFG_LIMIT2, 64'($urandom_range(100, 40)));
    run_words(300);

    // Zero limit finishes the sequence; then run on in the done phase
    cfg_write(CFG_LIMIT2, '0);
    cfg_write(CFG_MARKER1, '0);
    cfg_write(CFG_LIMIT1, '1);
    run_words(250);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### marker_phase_instruction_counter.f
hw/rtl/mpic_pkg.sv
hw/rtl/mpic_fifo.sv
hw/rtl/mpic_front.sv
hw/rtl/mpic_back.sv
hw/rtl/marker_phase_instruction_counter.sv
sim/tb_top.sv
